FILE: src/fcrc_pkg.sv
// ============================================================================
// fcrc_pkg: shared types, constants and functions of the flap cell row
// compositor.
// ============================================================================
package fcrc_pkg;

  localparam int unsigned MASK_BITS_DEF = 16;

  localparam int unsigned ROW_W   = 6;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned BITS_W  = 16;
  localparam int unsigned XOFF_W  = 6;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned CW_W    = 8;
  localparam int unsigned CHT_W   = 7;
  localparam int unsigned FW_W    = 5;
  localparam int unsigned FH_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CW_W-1:0]  CELL_WIDTH_RST  = 8'd12;
  localparam logic [CHT_W-1:0] CELL_HEIGHT_RST = 7'd16;
  localparam logic [FW_W-1:0]  FONT_WIDTH_RST  = 5'd8;
  localparam logic [FH_W-1:0]  FONT_HEIGHT_RST = 6'd12;

  localparam int unsigned WARM_R = 255;
  localparam int unsigned WARM_G = 244;
  localparam int unsigned WARM_B = 224;
  localparam int unsigned FADE   = 150;
  localparam logic [7:0] CREASE_R = 8'(WARM_R * FADE / 255);
  localparam logic [7:0] CREASE_G = 8'(WARM_G * FADE / 255);
  localparam logic [7:0] CREASE_B = 8'(WARM_B * FADE / 255);

  localparam logic [XOFF_W-1:0] XOFF_MAX = {XOFF_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH  = 2'd0,
    CFG_CELL_HEIGHT = 2'd1,
    CFG_FONT_WIDTH  = 2'd2,
    CFG_FONT_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One face of the flap as it arrives with the row.
  typedef struct packed {
    logic signed [IDX_W-1:0] colour;
    logic signed [IDX_W-1:0] tint;
    logic                    has_glyph;
    logic [BITS_W-1:0]       row_bits;
  } face_t;

  localparam rgb_t WARM_WHITE = '{red: 8'(WARM_R), green: 8'(WARM_G), blue: 8'(WARM_B)};
  localparam rgb_t CREASE_INK = '{red: CREASE_R, green: CREASE_G, blue: CREASE_B};

  // Palette lookup; indices six and seven fall on the last entry, white.
  function automatic rgb_t palette(input logic [2:0] idx);
    rgb_t p;
    case (idx)
      3'd0:    p = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      3'd1:    p = '{red: 8'd255, green: 8'd96,  blue: 8'd0};
      3'd2:    p = '{red: 8'd255, green: 8'd200, blue: 8'd0};
      3'd3:    p = '{red: 8'd0,   green: 8'd210, blue: 8'd60};
      3'd4:    p = '{red: 8'd0,   green: 8'd90,  blue: 8'd255};
      3'd5:    p = '{red: 8'd180, green: 8'd0,   blue: 8'd220};
      default: p = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    endcase
    return p;
  endfunction

  // Ones in the n leftmost columns, n clipped to mb columns.
  function automatic logic [BITS_W-1:0] left_ones(input logic [FW_W-1:0] n,
                                                  input int unsigned mb);
    logic [FW_W-1:0] nc;
    nc = n;
    if (nc > FW_W'(mb)) nc = FW_W'(mb);
    return ~({BITS_W{1'b1}} >> nc);
  endfunction

endpackage

FILE: src/fcrc_face.sv
// ============================================================================
// fcrc_face: mask and ink of one flap face
// Swatch, glyph or blank face for a row, given the row's band test.
// ============================================================================
module fcrc_face
  import fcrc_pkg::*;
(
  input  face_t             face,
  input  logic              in_band,
  input  logic [BITS_W-1:0] box_mask,
  input  logic [BITS_W-1:0] clip_mask,
  output logic [BITS_W-1:0] mask,
  output rgb_t              ink
);

  always_comb begin
    if (!in_band) begin
      mask = '0;
    end else if (!face.colour[IDX_W-1]) begin
      mask = box_mask;
    end else if (!face.has_glyph) begin
      mask = '0;
    end else begin
      mask = face.row_bits & clip_mask;
    end
  end

  // Swatch colour first, then glyph tint, else warm white.
  always_comb begin
    if (!face.colour[IDX_W-1]) begin
      ink = palette(face.colour[2:0]);
    end else if (!face.tint[IDX_W-1]) begin
      ink = palette(face.tint[2:0]);
    end else begin
      ink = WARM_WHITE;
    end
  end

endmodule

FILE: src/flap_cell_row_compositor_unit.sv
// ============================================================================
// flap_cell_row_compositor_unit: one pixel row of a split-flap cell
// Lit-column mask, horizontal offset and ink for one row of a cell.
// ============================================================================
// An accepted item moves from the input register to the result register.
// Throughput: one item per cycle; an input register and a result register
// carry the items, so a row enters every cycle while out_ready holds high.
// Reset (rst_n low, synchronous): both stage valid bits clear, and the geometry
// registers return to cell 12x16 and font 8x12.
module flap_cell_row_compositor_unit
  import fcrc_pkg::*;
#(
  parameter int unsigned MASK_BITS = MASK_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // row item in
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ROW_W-1:0]        in_local_row,
  input  logic                    in_mid_flip,
  input  logic signed [IDX_W-1:0] in_cur_colour,
  input  logic signed [IDX_W-1:0] in_cur_tint,
  input  logic                    in_cur_has_glyph,
  input  logic [BITS_W-1:0]       in_cur_row_bits,
  input  logic signed [IDX_W-1:0] in_next_colour,
  input  logic signed [IDX_W-1:0] in_next_tint,
  input  logic                    in_next_has_glyph,
  input  logic [BITS_W-1:0]       in_next_row_bits,
  // result item out
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [XOFF_W-1:0]       out_x_offset,
  output logic [BITS_W-1:0]       out_row_mask,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue
);

  // --------------------------------------------------------------------------
  // Geometry registers; writes are always taken.
  // --------------------------------------------------------------------------
  logic [CW_W-1:0]  cell_width_r;
  logic [CHT_W-1:0] cell_height_r;
  logic [FW_W-1:0]  font_width_r;
  logic [FH_W-1:0]  font_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= CELL_WIDTH_RST;
      cell_height_r <= CELL_HEIGHT_RST;
      font_width_r  <= FONT_WIDTH_RST;
      font_height_r <= FONT_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CELL_WIDTH:  cell_width_r  <= cfg_data[CW_W-1:0];
        CFG_CELL_HEIGHT: cell_height_r <= cfg_data[CHT_W-1:0];
        CFG_FONT_WIDTH:  font_width_r  <= cfg_data[FW_W-1:0];
        CFG_FONT_HEIGHT: font_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the result register loads when empty or being drained; the
  // input register advances when empty or whenever the result register loads.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_load;

  assign out_load  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_load;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (out_load) out_valid_r <= s1_valid_r;
    end
  end

  // Input register: payload only, no reset.
  logic [ROW_W-1:0] row_r;
  logic             flip_r;
  face_t            cur_r;
  face_t            nxt_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row_r  <= in_local_row;
      flip_r <= in_mid_flip;
      cur_r  <= '{colour: in_cur_colour, tint: in_cur_tint,
                  has_glyph: in_cur_has_glyph, row_bits: in_cur_row_bits};
      nxt_r  <= '{colour: in_next_colour, tint: in_next_tint,
                  has_glyph: in_next_has_glyph, row_bits: in_next_row_bits};
    end
  end

  // --------------------------------------------------------------------------
  // Cell geometry from the registers.
  // --------------------------------------------------------------------------
  logic [CW_W-1:0]       pad_x_full;
  logic [XOFF_W-1:0]     pad_x;
  logic [FH_W-1:0]       pad_y;
  logic [CHT_W-1:0]      band_end;
  logic [CHT_W-1:0]      seam_raw;
  logic [CHT_W-1:0]      seam_lo;
  logic signed [CH_W:0]  seam_lim;
  logic signed [CH_W:0]  seam;
  logic [FW_W-1:0]       clip_w;
  logic [BITS_W-1:0]     box_mask;
  logic [BITS_W-1:0]     clip_mask;

  always_comb begin
    // Half the size difference, zero when the font is the larger.
    pad_x_full = (cell_width_r > CW_W'(font_width_r))
               ? ((cell_width_r - CW_W'(font_width_r)) >> 1) : '0;
    pad_x      = (pad_x_full > CW_W'(XOFF_MAX)) ? XOFF_MAX : pad_x_full[XOFF_W-1:0];
    pad_y      = (cell_height_r > CHT_W'(font_height_r))
               ? FH_W'((cell_height_r - CHT_W'(font_height_r)) >> 1) : '0;
    band_end   = CHT_W'(pad_y) + CHT_W'(font_height_r);
    // Fold row: raise to one, then lower to cell height minus two, which may
    // go negative on tiny cells and then matches no row.
    seam_raw   = CHT_W'(pad_y) + CHT_W'(font_height_r[FH_W-1:1]);
    seam_lo    = (seam_raw == '0) ? CHT_W'(1) : seam_raw;
    seam_lim   = $signed({2'b00, cell_height_r}) - 9'sd2;
    seam       = ($signed({2'b00, seam_lo}) > seam_lim) ? seam_lim
               : $signed({2'b00, seam_lo});
    clip_w     = (CW_W'(font_width_r) < cell_width_r) ? font_width_r
               : cell_width_r[FW_W-1:0];
    box_mask   = left_ones(font_width_r, MASK_BITS);
    clip_mask  = left_ones(clip_w, MASK_BITS);
  end

  // --------------------------------------------------------------------------
  // Row classification and face selection.
  // --------------------------------------------------------------------------
  logic                 in_cell;
  logic                 in_band;
  logic signed [CH_W:0] row_s;
  logic [BITS_W-1:0]    cur_mask;
  logic [BITS_W-1:0]    nxt_mask;
  rgb_t                 cur_ink;
  rgb_t                 nxt_ink;

  assign row_s   = $signed({3'b000, row_r});
  assign in_cell = CHT_W'(row_r) < cell_height_r;
  assign in_band = (row_r >= pad_y) && (CHT_W'(row_r) < band_end);

  fcrc_face u_cur_face (
    .face      (cur_r),
    .in_band   (in_band),
    .box_mask  (box_mask),
    .clip_mask (clip_mask),
    .mask      (cur_mask),
    .ink       (cur_ink)
  );

  fcrc_face u_nxt_face (
    .face      (nxt_r),
    .in_band   (in_band),
    .box_mask  (box_mask),
    .clip_mask (clip_mask),
    .mask      (nxt_mask),
    .ink       (nxt_ink)
  );

  logic [BITS_W-1:0] mask_nxt;
  rgb_t              ink_sel;
  rgb_t              ink_nxt;

  always_comb begin
    mask_nxt = '0;
    ink_sel  = cur_ink;
    if (in_cell) begin
      if (!flip_r || row_s > seam) begin
        mask_nxt = cur_mask;
        ink_sel  = cur_ink;
      end else if (row_s < seam) begin
        // above the fold: the incoming face
        mask_nxt = nxt_mask;
        ink_sel  = nxt_ink;
      end else begin
        // the fold row: a faded crease across the glyph box
        mask_nxt = box_mask;
        ink_sel  = CREASE_INK;
      end
    end
    // Drop the ink when nothing is lit.
    ink_nxt = (mask_nxt == '0) ? '0 : ink_sel;
  end

  // Result register: payload only, no reset.
  logic [XOFF_W-1:0] x_offset_r;
  logic [BITS_W-1:0] row_mask_r;
  rgb_t              ink_r;

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      x_offset_r <= pad_x;
      row_mask_r <= mask_nxt;
      ink_r      <= ink_nxt;
    end
  end

  assign out_x_offset = x_offset_r;
  assign out_row_mask = row_mask_r;
  assign out_red      = ink_r.red;
  assign out_green    = ink_r.green;
  assign out_blue     = ink_r.blue;

endmodule

FILE: src/fcrc_checker.sv
// ============================================================================
// fcrc_checker: port-level checks of the row compositor
// Watches the handshakes and result fields; bound to the top level.
// ============================================================================
module fcrc_checker
  import fcrc_pkg::*;
#(
  parameter int unsigned MASK_BITS = MASK_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [XOFF_W-1:0] out_x_offset,
  input logic [BITS_W-1:0] out_row_mask,
  input logic [7:0]        out_red,
  input logic [7:0]        out_green,
  input logic [7:0]        out_blue
);

  localparam logic [BITS_W-1:0] BEYOND = {BITS_W{1'b1}} >> MASK_BITS;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_mask)
      && $stable(out_x_offset) && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  // An unlit row carries no ink.
  a_dark_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_mask == '0 |-> out_red == '0 && out_green == '0
      && out_blue == '0)
    else $error("ink on an unlit row");

  // No column past the mask width lights.
  a_mask_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_mask & BEYOND) == '0)
    else $error("column beyond mask width lit");

  // Input stalls only behind a stalled full result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without back-pressure");

endmodule

bind flap_cell_row_compositor_unit fcrc_checker #(.MASK_BITS(MASK_BITS)) u_fcrc_checker (.*);
